>>> rtl/core/rgb_to_hsv_convert_unit_defines.svh
// Assertion macros for the RGB to HSV conversion unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RGBHSV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RGBHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rgbhsv_pkg.sv
// Types and constants for the RGB to HSV conversion unit.
// No dependencies; imported by rgb_to_hsv_convert_unit.
package rgbhsv_pkg;

   localparam int unsigned ChanW      = 8;
   localparam int unsigned HueW       = 16;
   localparam int unsigned PctW       = 14;
   localparam int unsigned ChanDepth  = 1 << ChanW;

   localparam int unsigned HueScale   = 6000;   // 60 degrees in hundredths
   localparam int unsigned HueOffG    = 12000;  // 120 degrees in hundredths
   localparam int unsigned HueOffB    = 24000;  // 240 degrees in hundredths
   localparam int unsigned HueFull    = 36000;  // 360 degrees in hundredths
   localparam int unsigned PctScale   = 10000;  // 100 percent in hundredths
   localparam int unsigned ChanFull   = 255;

   // Scaled dividends stay below 2^ProdW, so a reciprocal with RecipShift
   // fraction bits leaves a quotient that is low by at most one.
   localparam int unsigned ProdW      = 22;
   localparam int unsigned RecipShift = 22;
   localparam int unsigned RecipW     = RecipShift + 1;
   localparam int unsigned MulW       = ProdW + RecipW;
   localparam int unsigned QuotW      = 14;
   localparam int unsigned RemW       = ChanW + 1;
   localparam int unsigned RecipFull  = (1 << RecipShift) / ChanFull;

   typedef enum logic [1:0] {
      WIN_RED   = 2'd0,
      WIN_GREEN = 2'd1,
      WIN_BLUE  = 2'd2
   } winner_type;

endpackage

>>> rtl/core/rgb_to_hsv_convert_unit.sv
// Five-stage pipelined RGB to HSV converter, one pixel per clock while busy is low.
// Depends on rgbhsv_pkg and rgb_to_hsv_convert_unit_defines.svh.
//
// A pixel is taken on any clock edge where start is high and busy is low; busy is
// high only during reset and the cycle after it. Each pixel yields exactly one
// transaction on the rsp_ ports, flagged by a one-cycle rsp_valid
// strobe. The receiver cannot stall, so a new pixel may enter every cycle and results
// leave in order at the same rate. Hue is in hundredths of a degree, saturation and
// brightness in hundredths of a percent, all truncated. Divisions use a reciprocal
// table followed by one remainder correction, which sets the depth of five stages.
`include "rgb_to_hsv_convert_unit_defines.svh"

module rgb_to_hsv_convert_unit
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ChanW-1:0]  req_red,
   input  logic [ChanW-1:0]  req_green,
   input  logic [ChanW-1:0]  req_blue,
   output logic              rsp_valid,
   output logic [HueW-1:0]   rsp_hue,
   output logic [PctW-1:0]   rsp_saturation,
   output logic [PctW-1:0]   rsp_brightness
);

   // Reciprocal table: floor(2^RecipShift / d), zero for d of zero.
   logic [RecipW-1:0] recip_tab [ChanDepth];
   for (genvar i = 0; i < ChanDepth; i++) begin : g_recip
      localparam int unsigned Entry = (i == 0) ? 0 : (1 << RecipShift) / i;
      assign recip_tab[i] = RecipW'(Entry);
   end

   logic busy_ff;
   logic accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         v5_ff   <= v4_ff;
      end
   end

   // Stage 1: max, min, winning channel and signed channel difference.
   winner_type       sel1_in, sel1_ff;
   logic [ChanW-1:0] mx1_in, mn1, dif_a, dif_c;
   logic [ChanW-1:0] mx1_ff, delta1_ff, absd1_in, absd1_ff;
   logic             neg1_in, neg1_ff;

   always_comb begin
      if (req_red >= req_green && req_red >= req_blue) begin
         sel1_in = WIN_RED;
         mx1_in  = req_red;
         mn1     = (req_green < req_blue) ? req_green : req_blue;
         dif_a   = req_green;
         dif_c   = req_blue;
      end else if (req_green >= req_red && req_green >= req_blue) begin
         sel1_in = WIN_GREEN;
         mx1_in  = req_green;
         mn1     = (req_red < req_blue) ? req_red : req_blue;
         dif_a   = req_blue;
         dif_c   = req_red;
      end else begin
         sel1_in = WIN_BLUE;
         mx1_in  = req_blue;
         mn1     = (req_red < req_green) ? req_red : req_green;
         dif_a   = req_red;
         dif_c   = req_green;
      end
      neg1_in  = dif_a < dif_c;
      absd1_in = neg1_in ? (dif_c - dif_a) : (dif_a - dif_c);
   end

   always_ff @(posedge clock) begin
      sel1_ff   <= sel1_in;
      mx1_ff    <= mx1_in;
      delta1_ff <= mx1_in - mn1;
      absd1_ff  <= absd1_in;
      neg1_ff   <= neg1_in;
   end

   // Stage 2: scaled dividends and reciprocal lookups.
   logic [ProdW-1:0]  x2_ff, y2_ff, z2_ff;
   logic [RecipW-1:0] rh2_ff, rs2_ff;
   logic [ChanW-1:0]  mx2_ff, delta2_ff;
   winner_type        sel2_ff;
   logic              neg2_ff, gray2_ff;

   always_ff @(posedge clock) begin
      x2_ff     <= ProdW'(absd1_ff) * ProdW'(HueScale);
      y2_ff     <= ProdW'(delta1_ff) * ProdW'(PctScale);
      z2_ff     <= ProdW'(mx1_ff) * ProdW'(PctScale);
      rh2_ff    <= recip_tab[delta1_ff];
      rs2_ff    <= recip_tab[mx1_ff];
      mx2_ff    <= mx1_ff;
      delta2_ff <= delta1_ff;
      sel2_ff   <= sel1_ff;
      neg2_ff   <= neg1_ff;
      gray2_ff  <= (delta1_ff == '0);
   end

   // Stage 3: estimated quotients, each equal to the true one or one below it.
   logic [MulW-1:0]  ph3, ps3, pv3;
   logic [QuotW-1:0] qh3_ff, qs3_ff, qv3_ff;
   logic [ProdW-1:0] x3_ff, y3_ff, z3_ff;
   logic [ChanW-1:0] mx3_ff, delta3_ff;
   winner_type       sel3_ff;
   logic             neg3_ff, gray3_ff;

   assign ph3 = MulW'(x2_ff) * MulW'(rh2_ff);
   assign ps3 = MulW'(y2_ff) * MulW'(rs2_ff);
   assign pv3 = MulW'(z2_ff) * MulW'(RecipFull);

   always_ff @(posedge clock) begin
      qh3_ff    <= ph3[RecipShift +: QuotW];
      qs3_ff    <= ps3[RecipShift +: QuotW];
      qv3_ff    <= pv3[RecipShift +: QuotW];
      x3_ff     <= x2_ff;
      y3_ff     <= y2_ff;
      z3_ff     <= z2_ff;
      mx3_ff    <= mx2_ff;
      delta3_ff <= delta2_ff;
      sel3_ff   <= sel2_ff;
      neg3_ff   <= neg2_ff;
      gray3_ff  <= gray2_ff;
   end

   // Stage 4: remainders of the estimated quotients.
   logic [ProdW-1:0] remh4_full, rems4_full, remv4_full;
   logic [RemW-1:0]  remh4_ff, rems4_ff, remv4_ff;
   logic [QuotW-1:0] qh4_ff, qs4_ff, qv4_ff;
   logic [ChanW-1:0] mx4_ff, delta4_ff;
   winner_type       sel4_ff;
   logic             neg4_ff, gray4_ff;

   assign remh4_full = x3_ff - ProdW'(qh3_ff) * ProdW'(delta3_ff);
   assign rems4_full = y3_ff - ProdW'(qs3_ff) * ProdW'(mx3_ff);
   assign remv4_full = z3_ff - ProdW'(qv3_ff) * ProdW'(ChanFull);

   always_ff @(posedge clock) begin
      remh4_ff  <= remh4_full[RemW-1:0];
      rems4_ff  <= rems4_full[RemW-1:0];
      remv4_ff  <= remv4_full[RemW-1:0];
      qh4_ff    <= qh3_ff;
      qs4_ff    <= qs3_ff;
      qv4_ff    <= qv3_ff;
      mx4_ff    <= mx3_ff;
      delta4_ff <= delta3_ff;
      sel4_ff   <= sel3_ff;
      neg4_ff   <= neg3_ff;
      gray4_ff  <= gray3_ff;
   end

   // Stage 5: quotient correction and hue offset.
   logic [QuotW-1:0] qh5, qs5, qv5;
   logic             inexact5;
   logic [HueW-1:0]  base5, hue5_in;
   logic [HueW-1:0]  hue_ff;
   logic [PctW-1:0]  sat_ff, val_ff;

   always_comb begin
      qh5 = qh4_ff + QuotW'(remh4_ff >= RemW'(delta4_ff));
      qs5 = qs4_ff + QuotW'((mx4_ff != '0) && (rems4_ff >= RemW'(mx4_ff)));
      qv5 = qv4_ff + QuotW'(remv4_ff >= RemW'(ChanFull));
      // The division is exact when the remainder is zero before or after correction.
      inexact5 = (remh4_ff != '0) && (remh4_ff != RemW'(delta4_ff));
      case (sel4_ff)
         WIN_GREEN: base5 = HueW'(HueOffG);
         WIN_BLUE:  base5 = HueW'(HueOffB);
         default:   base5 = '0;
      endcase
      // A negative difference counts down from the offset, or from a full turn when
      // red wins; the quotient is rounded up so that the hue stays truncated.
      if (gray4_ff) begin
         hue5_in = '0;
      end else if (neg4_ff) begin
         hue5_in = ((sel4_ff == WIN_RED) ? HueW'(HueFull) : base5) - HueW'(qh5) -
                   HueW'(inexact5);
      end else begin
         hue5_in = base5 + HueW'(qh5);
      end
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue5_in;
      sat_ff <= PctW'(qs5);
      val_ff <= PctW'(qv5);
   end

   assign rsp_valid      = v5_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = val_ff;

   `RGBHSV_ASSERT_NEXT(a_accept_enters, clock, reset, accept, v1_ff,
                       "accepted pixel did not enter the pipeline")
   `RGBHSV_ASSERT_IMPL(a_hue_rem_bound, clock, reset, v4_ff && !gray4_ff,
                       remh4_ff < (RemW'(delta4_ff) << 1),
                       "hue quotient estimate off by more than one")
   `RGBHSV_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid,
                       rsp_hue < HueW'(HueFull), "hue out of range")
   `RGBHSV_ASSERT_IMPL(a_pct_range, clock, reset, rsp_valid,
                       rsp_saturation <= PctW'(PctScale) &&
                       rsp_brightness <= PctW'(PctScale),
                       "saturation or brightness out of range")

endmodule

>>> bench/tb_rgb_to_hsv_convert_unit.sv
// Self-checking testbench for rgb_to_hsv_convert_unit: directed and random pixels,
// with a scoreboard class that predicts hue, saturation and value in fixed point.
// Depends on rgbhsv_pkg and the rgb_to_hsv_convert_unit RTL.
module tb_rgb_to_hsv_convert_unit
   import rgbhsv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomPixels = 1600;
   localparam int unsigned DrainCycles  = 12;

   typedef struct packed {
      logic [HueW-1:0] hue;
      logic [PctW-1:0] sat;
      logic [PctW-1:0] val;
   } hsv_type;

   class hsv_scoreboard;
      localparam int HueStep  = 6000;
      localparam int HueGreen = 12000;
      localparam int HueBlue  = 24000;
      localparam int HueTurn  = 36000;
      localparam int PctFull  = 10000;
      localparam int ChanMax  = 255;

      hsv_type     expected_q[$];
      int unsigned pixels_seen;
      int unsigned results_checked;
      int unsigned mismatches;

      function hsv_type hsv_of_pixel(logic [ChanW-1:0] r8, logic [ChanW-1:0] g8,
                                     logic [ChanW-1:0] b8);
         int r, g, b, mx, mn, diff, base, delta, num;
         winner_type win;
         hsv_type res;
         r = r8;
         g = g8;
         b = b8;
         // Red wins any tie for the largest channel, then green.
         if (r >= g && r >= b) win = WIN_RED;
         else if (g >= b) win = WIN_GREEN;
         else win = WIN_BLUE;
         case (win)
            WIN_RED: begin
               mx = r; mn = (g < b) ? g : b; diff = g - b; base = 0;
            end
            WIN_GREEN: begin
               mx = g; mn = (r < b) ? r : b; diff = b - r; base = HueGreen;
            end
            default: begin
               mx = b; mn = (r < g) ? r : g; diff = r - g; base = HueBlue;
            end
         endcase
         delta = mx - mn;
         res = '0;
         if (delta > 0) begin
            num = HueStep * diff + base * delta;
            // The wrap into one turn is applied before the truncating division.
            if (num < 0) num += HueTurn * delta;
            res.hue = HueW'(num / delta);
         end
         if (mx > 0) res.sat = PctW'((PctFull * delta) / mx);
         res.val = PctW'((PctFull * mx) / ChanMax);
         return res;
      endfunction

      function void note_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                               logic [ChanW-1:0] b);
         expected_q.push_back(hsv_of_pixel(r, g, b));
         pixels_seen++;
      endfunction

      function void check_result(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                                 logic [PctW-1:0] val);
         hsv_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: result with no pixel pending: hue %0d sat %0d val %0d",
                     $time, hue, sat, val);
            mismatches++;
            return;
         end
         exp_res = expected_q.pop_front();
         results_checked++;
         if (hue !== exp_res.hue) begin
            $display("%0t: hue mismatch: expected %0d, actual %0d", $time, exp_res.hue, hue);
            mismatches++;
         end
         if (sat !== exp_res.sat) begin
            $display("%0t: saturation mismatch: expected %0d, actual %0d",
                     $time, exp_res.sat, sat);
            mismatches++;
         end
         if (val !== exp_res.val) begin
            $display("%0t: brightness mismatch: expected %0d, actual %0d",
                     $time, exp_res.val, val);
            mismatches++;
         end
      endfunction
   endclass

   // Black, white, gray, primaries, ties for the largest channel, the
   // wrapped hue of a red winner with green below blue, and near-extremes.
   localparam logic [23:0] CornerPixels [22] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFF0001, 24'hFF00FF, 24'hFFFF00, 24'h00FFFF, 24'h010000,
      24'h000100, 24'h000001, 24'hFEFF00, 24'h00FEFF, 24'hFF00FE, 24'h7F0080,
      24'h010001, 24'hFF0102, 24'h80FF7F, 24'hFE01FF
   };

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [ChanW-1:0] req_red;
   logic [ChanW-1:0] req_green;
   logic [ChanW-1:0] req_blue;
   logic             rsp_valid;
   logic [HueW-1:0]  rsp_hue;
   logic [PctW-1:0]  rsp_saturation;
   logic [PctW-1:0]  rsp_brightness;

   hsv_scoreboard board = new;

   rgb_to_hsv_convert_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both channels are observed at the edge that completes each transaction.
   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_pixel(req_red, req_green, req_blue);
      if (!reset && rsp_valid) board.check_result(rsp_hue, rsp_saturation, rsp_brightness);
   end

   task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b);
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic maybe_idle(input int unsigned percent);
      if ($urandom_range(99) < percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      int unsigned idle_pct [3];
      logic [ChanW-1:0] px [3];
      int base, v;
      idle_pct  = '{19, 51, 0};
      reset     <= 1'b1;
      start     <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (CornerPixels[i])
         send_pixel(CornerPixels[i][23:16], CornerPixels[i][15:8], CornerPixels[i][7:0]);

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RandomPixels / 3; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  foreach (px[c]) px[c] = ChanW'($urandom_range(255));
               end
               4, 5: begin
                  // Nearly gray: a tiny spread makes the hue division sensitive.
                  base = $urandom_range(255);
                  foreach (px[c]) begin
                     v = base + int'($urandom_range(6)) - 3;
                     if (v < 0) v = 0;
                     if (v > 255) v = 255;
                     px[c] = ChanW'(v);
                  end
               end
               6: begin
                  foreach (px[c]) px[c] = ChanW'($urandom_range(255));
                  px[$urandom_range(2)] = px[$urandom_range(2)];
               end
               7: begin
                  foreach (px[c]) begin
                     case ($urandom_range(3))
                        0: px[c] = 8'd0;
                        1: px[c] = 8'd1;
                        2: px[c] = 8'd254;
                        default: px[c] = 8'd255;
                     endcase
                  end
               end
               8: begin
                  foreach (px[c]) px[c] = ChanW'($urandom_range(255));
                  px[$urandom_range(2)] = '0;
               end
               default: begin
                  foreach (px[c]) px[c] = ChanW'($urandom_range(255));
                  px[$urandom_range(2)] = 8'd255;
               end
            endcase
            maybe_idle(idle_pct[phase]);
            send_pixel(px[0], px[1], px[2]);
         end
      end

      start <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Converted %0d pixels (directed corners, then random under three pacing modes).",
               board.pixels_seen);
      $display("Compared %0d results field by field, %0d mismatches.",
               board.results_checked, board.mismatches);
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Timed out with %0d results still pending.", board.expected_q.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
